// ----- rtl/octahedral_normal_encode_core_macros.svh -----
// Assertion macros for the octahedral normal encoder checker.
// Used by onenc_checker; no other dependencies.
`ifndef OCTAHEDRAL_NORMAL_ENCODE_CORE_MACROS_SVH
`define OCTAHEDRAL_NORMAL_ENCODE_CORE_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ONENC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define ONENC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define ONENC_ASSERT_NXT_ALL(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/onenc_pkg.sv -----
// Package for the octahedral normal encoder: request, response and stage types.
// No dependencies.
`timescale 1ns / 1ps

package onenc_pkg;

    localparam int unsigned DIV_BITS = 17;
    localparam int unsigned REM_W    = 34;
    localparam int unsigned DEN_W    = 18;
    localparam int unsigned MAG_W    = 17;

    localparam logic [17:0] ONE_Q16    = 18'd65536;
    localparam logic [15:0] CENTRE_Q16 = 16'd32768;
    localparam logic [15:0] MAX_U16    = 16'hFFFF;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } t_req;

    typedef struct packed {
        logic [15:0] enc_u;
        logic [15:0] enc_v;
        logic        zero_vector;
    } t_rsp;

    typedef struct packed {
        logic [REM_W-1:0]    rem_x;
        logic [REM_W-1:0]    rem_y;
        logic [DEN_W-1:0]    den;
        logic [DIV_BITS-1:0] q_x;
        logic [DIV_BITS-1:0] q_y;
        logic                neg_x;
        logic                neg_y;
        logic                neg_z;
        logic                zero;
    } t_stage;

endpackage

// ----- rtl/octahedral_normal_encode_core.sv -----
// Top level of the octahedral normal encoder: input cell, division cells, output cell.
// Depends on onenc_pkg, onenc_prep, onenc_div_cell and onenc_finish.
//
//   Channel   Valid     Stall     Payload
//   request   i_valid   o_stall   i_req (t_req)
//   response  o_valid   i_stall   o_rsp (t_rsp)
//
// One request is taken every cycle while o_stall is low; each request passes through one
// input cell, 17 restoring division cells (one quotient bit each, x and y side by side)
// and the output register.
// Reset is synchronous and clears only the valid bit of every cell.
// A stall holds the response register; the cells behind it keep advancing into
// empty slots, so o_stall rises only once every cell holds a request.
`timescale 1ns / 1ps

module octahedral_normal_encode_core
    import onenc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    localparam int unsigned NUM_STAGES = DIV_BITS + 2;

    logic [NUM_STAGES-1:0] w_vld;
    logic [NUM_STAGES-1:0] w_en;
    t_stage                w_data [DIV_BITS+1];

    assign w_en[NUM_STAGES-1] = !w_vld[NUM_STAGES-1] || !i_stall;

    genvar k;
    generate
        for (k = 0; k < NUM_STAGES - 1; k++) begin : g_en
            assign w_en[k] = !w_vld[k] || w_en[k+1];
        end
    endgenerate

    onenc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en[0]),
        .i_vld   (i_valid),
        .i_req   (i_req),
        .o_vld   (w_vld[0]),
        .o_data  (w_data[0])
    );

    generate
        for (k = 0; k < DIV_BITS; k++) begin : g_cell
            onenc_div_cell #(
                .BIT_POS (DIV_BITS - 1 - k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en[k+1]),
                .i_vld   (w_vld[k]),
                .i_data  (w_data[k]),
                .o_vld   (w_vld[k+1]),
                .o_data  (w_data[k+1])
            );
        end
    endgenerate

    onenc_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en[NUM_STAGES-1]),
        .i_vld   (w_vld[NUM_STAGES-2]),
        .i_data  (w_data[DIV_BITS]),
        .o_vld   (w_vld[NUM_STAGES-1]),
        .o_rsp   (o_rsp)
    );

    assign o_stall = !w_en[0];
    assign o_valid = w_vld[NUM_STAGES-1];

endmodule

// ----- rtl/onenc_prep.sv -----
// Input cell: magnitudes, L1 norm and dividend set-up for both quotients.
// Depends on onenc_pkg.
`timescale 1ns / 1ps

module onenc_prep
    import onenc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_vld,
    input  t_req   i_req,
    output logic   o_vld,
    output t_stage o_data
);

    logic signed [16:0] w_xe, w_ye, w_ze;
    logic [MAG_W-1:0]   w_ax, w_ay, w_az, w_l1;
    t_stage             n_data;
    t_stage             r_data;
    logic               r_vld;

    always_comb begin
        w_xe = 17'(i_req.dir_x);
        w_ye = 17'(i_req.dir_y);
        w_ze = 17'(i_req.dir_z);
        w_ax = w_xe[16] ? MAG_W'(-w_xe) : MAG_W'(w_xe);
        w_ay = w_ye[16] ? MAG_W'(-w_ye) : MAG_W'(w_ye);
        w_az = w_ze[16] ? MAG_W'(-w_ze) : MAG_W'(w_ze);
        w_l1 = w_ax + w_ay + w_az;
        n_data.rem_x = {w_ax, 17'd0} + REM_W'(w_l1);
        n_data.rem_y = {w_ay, 17'd0} + REM_W'(w_l1);
        n_data.den   = {w_l1, 1'b0};
        n_data.q_x   = '0;
        n_data.q_y   = '0;
        n_data.neg_x = i_req.dir_x[15];
        n_data.neg_y = i_req.dir_y[15];
        n_data.neg_z = i_req.dir_z[15];
        n_data.zero  = (w_l1 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

// ----- rtl/onenc_div_cell.sv -----
// Division cell: settles one quotient bit of each of the two quotients.
// Depends on onenc_pkg.
`timescale 1ns / 1ps

module onenc_div_cell
    import onenc_pkg::*;
#(
    parameter int unsigned BIT_POS = 0
)
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_vld,
    input  t_stage i_data,
    output logic   o_vld,
    output t_stage o_data
);

    logic [REM_W-1:0] w_step;
    logic             w_ge_x, w_ge_y;
    t_stage           n_data;
    t_stage           r_data;
    logic             r_vld;

    always_comb begin
        w_step = REM_W'(i_data.den) << BIT_POS;
        w_ge_x = (i_data.rem_x >= w_step);
        w_ge_y = (i_data.rem_y >= w_step);
        n_data       = i_data;
        n_data.rem_x = w_ge_x ? (i_data.rem_x - w_step) : i_data.rem_x;
        n_data.rem_y = w_ge_y ? (i_data.rem_y - w_step) : i_data.rem_y;
        n_data.q_x   = {i_data.q_x[DIV_BITS-2:0], w_ge_x};
        n_data.q_y   = {i_data.q_y[DIV_BITS-2:0], w_ge_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

// ----- rtl/onenc_finish.sv -----
// Output cell: hemisphere fold, sign, mapping to unsigned Q0.16 and saturation.
// Depends on onenc_pkg.
`timescale 1ns / 1ps

module onenc_finish
    import onenc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_vld,
    input  t_stage i_data,
    output logic   o_vld,
    output t_rsp   o_rsp
);

    logic [MAG_W-1:0]   w_mag_u, w_mag_v;
    logic signed [18:0] w_s_u, w_s_v, w_b_u, w_b_v;
    logic [17:0]        w_r_u, w_r_v;
    t_rsp               n_rsp;
    t_rsp               r_rsp;
    logic               r_vld;

    always_comb begin
        w_mag_u = i_data.neg_z ? MAG_W'(ONE_Q16 - 18'(i_data.q_y)) : i_data.q_x;
        w_mag_v = i_data.neg_z ? MAG_W'(ONE_Q16 - 18'(i_data.q_x)) : i_data.q_y;
        w_s_u   = i_data.neg_x ? -$signed({2'b00, w_mag_u}) : $signed({2'b00, w_mag_u});
        w_s_v   = i_data.neg_y ? -$signed({2'b00, w_mag_v}) : $signed({2'b00, w_mag_v});
        w_b_u   = w_s_u + 19'sd65537;
        w_b_v   = w_s_v + 19'sd65537;
        w_r_u   = w_b_u[18:1];
        w_r_v   = w_b_v[18:1];
        if (i_data.zero) begin
            n_rsp.enc_u       = CENTRE_Q16;
            n_rsp.enc_v       = CENTRE_Q16;
            n_rsp.zero_vector = 1'b1;
        end else begin
            n_rsp.enc_u       = (w_r_u[17:16] != 2'b00) ? MAX_U16 : w_r_u[15:0];
            n_rsp.enc_v       = (w_r_v[17:16] != 2'b00) ? MAX_U16 : w_r_v[15:0];
            n_rsp.zero_vector = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_vld = r_vld;
    assign o_rsp = r_rsp;

endmodule

// ----- rtl/onenc_checker.sv -----
// Port-level checker for the octahedral normal encoder, bound to the top level.
// Depends on onenc_pkg and octahedral_normal_encode_core_macros.svh.
`timescale 1ns / 1ps
`include "octahedral_normal_encode_core_macros.svh"

module onenc_checker
    import onenc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input t_req i_req,
    input logic o_valid,
    input logic i_stall,
    input t_rsp o_rsp
);

    `ONENC_ASSERT_NXT_ALL(a_reset_empties, i_clk, !i_rst_n, !o_valid, "response valid after reset")

    `ONENC_ASSERT_IMP(a_idle_no_stall, i_clk, i_rst_n, !o_valid, !o_stall, "request stalled with empty output")

    `ONENC_ASSERT_IMP(a_zero_centre, i_clk, i_rst_n, o_valid && o_rsp.zero_vector, (o_rsp.enc_u == CENTRE_Q16) && (o_rsp.enc_v == CENTRE_Q16), "zero vector not at centre")

    `ONENC_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_rsp), "stalled response changed")

    `ONENC_ASSERT_NXT(a_req_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid && $stable(i_req), "stalled request changed")

endmodule

bind octahedral_normal_encode_core onenc_checker u_onenc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_req   (i_req),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_rsp   (o_rsp)
);

// ----- tb/octa_normal_check.sv -----
// Checker for the octahedral normal encoder: watches both channels, predicts each response
// from its request and compares field by field. Depends on onenc_pkg for t_req and t_rsp.
`timescale 1ns / 1ps

module octa_normal_check
    import onenc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic o_stall,
    input  t_req i_req,
    input  logic o_valid,
    input  logic i_stall,
    input  t_rsp o_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    t_rsp expected_codes[$];
    int   mismatch_count = 0;
    int   waiting_count  = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = waiting_count;

    function automatic logic [15:0] map_to_unit(int s);
        int m;
        m = (s + 65537) >>> 1;
        if (m > 65535) begin
            m = 65535;
        end
        return m[15:0];
    endfunction

    function automatic t_rsp predict_encoding(t_req r);
        int x, y, z;
        int ax, ay, az, l1;
        longint unsigned mqx, mqy;
        int su, sv;
        t_rsp e;
        x  = r.dir_x;
        y  = r.dir_y;
        z  = r.dir_z;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        l1 = ax + ay + az;
        if (l1 == 0) begin
            e.enc_u       = CENTRE_Q16;
            e.enc_v       = CENTRE_Q16;
            e.zero_vector = 1'b1;
            return e;
        end
        mqx = (longint'(ax) * 131072 + l1) / (2 * l1);
        mqy = (longint'(ay) * 131072 + l1) / (2 * l1);
        if (z < 0) begin
            // The fold takes both unfolded quotients.
            su = 65536 - int'(mqy);
            sv = 65536 - int'(mqx);
        end else begin
            su = int'(mqx);
            sv = int'(mqy);
        end
        if (x < 0) begin
            su = -su;
        end
        if (y < 0) begin
            sv = -sv;
        end
        e.enc_u       = map_to_unit(su);
        e.enc_v       = map_to_unit(sv);
        e.zero_vector = 1'b0;
        return e;
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        $display("%0t ns: mismatch on %s, expected %0d, got %0d", $time, what, want, got);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_codes.push_back(predict_encoding(i_req));
            end
            if (o_valid && !i_stall) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch("unrequested response", 0, 1);
                end else begin
                    want = expected_codes.pop_front();
                    if (o_rsp.enc_u !== want.enc_u) begin
                        report_mismatch("enc_u", want.enc_u, o_rsp.enc_u);
                    end
                    if (o_rsp.enc_v !== want.enc_v) begin
                        report_mismatch("enc_v", want.enc_v, o_rsp.enc_v);
                    end
                    if (o_rsp.zero_vector !== want.zero_vector) begin
                        report_mismatch("zero_vector", want.zero_vector, o_rsp.zero_vector);
                    end
                end
            end
            waiting_count = expected_codes.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
// Top of the octahedral normal encoder testbench: clock, reset, request stimulus and
// response stalls, with the verdict. Depends on onenc_pkg, octa_normal_check and the core.
`timescale 1ns / 1ps

module tb
    import onenc_pkg::*;
;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall;
    t_rsp o_rsp;
    int   fail_count;
    int   pending;
    logic no_idle;
    int   stall_left;

    octahedral_normal_encode_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    octa_normal_check checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req        (i_req),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'hFFFF;
            2:       return 16'h0000;
            3:       return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    function automatic logic [15:0] pick_component(int kind);
        int s;
        case (kind)
            0: begin
                s = $urandom_range(0, 8);
                return 16'(s - 4);
            end
            1:       return pick_extreme();
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_req random_direction();
        t_req r;
        int   mode;
        mode = $urandom_range(0, 99);
        if (mode < 55) begin
            r.dir_x = pick_component(3);
            r.dir_y = pick_component(3);
            r.dir_z = pick_component(3);
        end else if (mode < 70) begin
            r.dir_x = pick_component(0);
            r.dir_y = pick_component(0);
            r.dir_z = pick_component(0);
        end else if (mode < 85) begin
            r.dir_x = pick_component($urandom_range(1, 3));
            r.dir_y = pick_component($urandom_range(1, 3));
            r.dir_z = pick_component($urandom_range(1, 3));
        end else begin
            r.dir_x = pick_component($urandom_range(0, 3));
            r.dir_y = pick_component($urandom_range(0, 3));
            r.dir_z = pick_component($urandom_range(0, 3));
        end
        return r;
    endfunction

    task automatic send_request(input logic [15:0] x, input logic [15:0] y,
                                input logic [15:0] z);
        int gap;
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_req.dir_x <= x;
        i_req.dir_y <= y;
        i_req.dir_z <= z;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            i_req   <= t_req'(48'({$urandom, $urandom}));
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n || no_idle) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 30) begin
            i_stall    <= 1'b1;
            stall_left <= ($urandom_range(0, 99) < 92) ? $urandom_range(0, 2)
                                                       : $urandom_range(19, 59);
        end else begin
            i_stall    <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end
    end

    initial begin
        t_req r;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_stall    = 1'b0;
        i_req      = '0;
        no_idle    = 1'b0;
        stall_left = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(16'h0000, 16'h0000, 16'h0000);
        send_request(16'h7FFF, 16'h0000, 16'h0000);
        send_request(16'h8000, 16'h0000, 16'h0000);
        send_request(16'h0000, 16'h7FFF, 16'h0000);
        send_request(16'h0000, 16'h8000, 16'h0000);
        send_request(16'h0000, 16'h0000, 16'h7FFF);
        send_request(16'h0000, 16'h0000, 16'h8000);
        send_request(16'h0000, 16'h0000, 16'hFFFF);
        send_request(16'h0000, 16'h0000, 16'h0001);
        send_request(16'h8000, 16'h8000, 16'h8000);
        send_request(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_request(16'h7FFF, 16'h8000, 16'hFFFF);
        send_request(16'h8000, 16'h7FFF, 16'h0000);
        send_request(16'h0001, 16'h0001, 16'hFFFF);
        send_request(16'hFFFF, 16'h0000, 16'h0000);
        send_request(16'h0000, 16'hFFFF, 16'h0000);
        send_request(16'hFFFB, 16'h0000, 16'hFFF9);
        send_request(16'h0000, 16'hFFFB, 16'hFFF9);
        send_request(16'h4000, 16'hC000, 16'h0000);
        send_request(16'hFFFF, 16'hFFFF, 16'h8000);
        send_request(16'h0001, 16'h0000, 16'hFFFF);
        send_request(16'h5555, 16'hAAAA, 16'h1234);

        for (int i = 0; i < 550; i++) begin
            if (i == 150) begin
                no_idle <= 1'b1;
            end else if (i == 260) begin
                no_idle <= 1'b0;
            end
            r = random_direction();
            send_request(r.dir_x, r.dir_y, r.dir_z);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
